// ----- src/lz77_pkg.sv -----
// shared types and constants of the lz77 token compressor
package lz77_pkg;

  localparam int HISTORY_DEPTH_DEF = 128;
  localparam int MAX_MATCH_DEF     = 32;

  typedef logic [7:0] byte_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_EMIT,
    ST_PUSH
  } state_t;

  // control broadcast to every history cell
  typedef struct packed {
    logic push;  // shift one consumed byte into the history chain
    logic load;  // copy history into the search window, arm candidates
    logic step;  // advance the search window by one byte
  } cell_ctrl_t;

endpackage

// ----- src/lz77_hist_cell.sv -----
// one history cell: stored byte, sliding search window byte and candidate flag
module lz77_hist_cell (
  input  logic                  clk,
  input  lz77_pkg::cell_ctrl_t  ctrl,
  input  lz77_pkg::byte_t       hist_prev,
  input  lz77_pkg::byte_t       win_prev,
  input  logic                  winv_prev,
  input  lz77_pkg::byte_t       la_byte,
  input  logic                  in_range,
  output lz77_pkg::byte_t       hist_o,
  output lz77_pkg::byte_t       win_o,
  output logic                  winv_o,
  output logic                  cand_o
);

  lz77_pkg::byte_t hist_r;
  lz77_pkg::byte_t win_r;
  logic            winv_r;
  logic            alive_r;

  // candidate still matches at the current lookahead position
  assign cand_o = alive_r && winv_r && (win_r == la_byte);

  assign hist_o = hist_r;
  assign win_o  = win_r;
  assign winv_o = winv_r;

  // history byte moves one place further back on each push
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      hist_r <= hist_prev;
    end
  end

  // search window and candidate flag
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      win_r   <= hist_r;
      winv_r  <= 1'b1;
      alive_r <= in_range;
    end else if (ctrl.step) begin
      win_r   <= win_prev;
      winv_r  <= winv_prev;
      alive_r <= cand_o;
    end
  end

endmodule

// ----- src/lz77_token_compressor_top.sv -----
// lz77 token compressor: lookahead buffer, chain of history cells and token sequencer
// When the lookahead is full or the stream ends, load copies history into the windows,
// which then step one lookahead byte per cycle through the cell chain while a candidate
// survives and bytes remain; the token is then emitted and pushed, one push per byte.
// Throughput: one byte per cycle while filling; no byte is taken while a token is
// searched, emitted or pushed, and the emit waits while an earlier token is held.
// Reset (rst_n low, synchronous) empties lookahead and history; stored bytes are not cleared.
module lz77_token_compressor_top #(
  parameter int HISTORY_DEPTH = lz77_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_MATCH     = lz77_pkg::MAX_MATCH_DEF,
  localparam int OW  = $clog2(HISTORY_DEPTH + 1),
  localparam int LW  = $clog2(MAX_MATCH + 1),
  localparam int LAW = (MAX_MATCH > 1) ? $clog2(MAX_MATCH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data_byte,
  input  logic          in_stream_end,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [OW-1:0] out_match_offset,
  output logic [LW-1:0] out_match_length,
  output logic [7:0]    out_lead_byte,
  output logic          out_run_last
);

  lz77_pkg::state_t     state_r, state_nxt;
  lz77_pkg::cell_ctrl_t ctrl;

  lz77_pkg::byte_t la_r [MAX_MATCH];
  logic [LW-1:0]   lcount_r, lcount_nxt;
  logic [OW-1:0]   hcount_r, hcount_nxt;
  logic            drain_r, drain_nxt;
  logic [LW-1:0]   n_r, n_nxt;
  logic [LW-1:0]   best_len_r, best_len_nxt;
  logic [OW-1:0]   best_off_r, best_off_nxt;
  logic [LW-1:0]   rem_r, rem_nxt;

  logic            out_valid_r;
  logic [OW-1:0]   out_off_r;
  logic [LW-1:0]   out_len_r;
  lz77_pkg::byte_t out_first_r;
  logic            out_last_r;

  logic            in_take;
  logic            emit_go;
  logic            any_cand;
  logic [OW-1:0]   first_off;
  lz77_pkg::byte_t la_sel;

  lz77_pkg::byte_t hist_w [HISTORY_DEPTH+1];
  lz77_pkg::byte_t win_w  [HISTORY_DEPTH+1];
  logic            winv_w [HISTORY_DEPTH+1];
  logic [HISTORY_DEPTH:1] cand_w;

  assign in_ready = (state_r == lz77_pkg::ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign la_sel   = la_r[n_r[LAW-1:0]];

  // chain head takes the oldest lookahead byte
  assign hist_w[0] = la_r[0];
  assign win_w[0]  = '0;
  assign winv_w[0] = 1'b0;

  // row of history cells, cell d holds the byte at distance d
  for (genvar d = 1; d <= HISTORY_DEPTH; d++) begin : g_cell
    lz77_hist_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .hist_prev (hist_w[d-1]),
      .win_prev  (win_w[d-1]),
      .winv_prev (winv_w[d-1]),
      .la_byte   (la_sel),
      .in_range  (hcount_r >= OW'(d)),
      .hist_o    (hist_w[d]),
      .win_o     (win_w[d]),
      .winv_o    (winv_w[d]),
      .cand_o    (cand_w[d])
    );
  end

  // nearest surviving candidate
  always_comb begin
    first_off = '0;
    for (int d = HISTORY_DEPTH; d >= 1; d--) begin
      if (cand_w[d]) begin
        first_off = OW'(d);
      end
    end
  end
  assign any_cand = |cand_w;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    lcount_nxt   = lcount_r;
    hcount_nxt   = hcount_r;
    drain_nxt    = drain_r;
    n_nxt        = n_r;
    best_len_nxt = best_len_r;
    best_off_nxt = best_off_r;
    rem_nxt      = rem_r;
    ctrl         = '0;
    emit_go      = 1'b0;
    unique case (state_r)
      lz77_pkg::ST_IDLE: begin
        if (in_take) begin
          lcount_nxt = lcount_r + LW'(1);
          if (in_stream_end) begin
            drain_nxt = 1'b1;
            state_nxt = lz77_pkg::ST_LOAD;
          end else if (lcount_r + LW'(1) == LW'(MAX_MATCH)) begin
            state_nxt = lz77_pkg::ST_LOAD;
          end
        end
      end
      lz77_pkg::ST_LOAD: begin
        ctrl.load    = 1'b1;
        n_nxt        = '0;
        best_len_nxt = LW'(1);
        best_off_nxt = '0;
        state_nxt    = lz77_pkg::ST_SCAN;
      end
      lz77_pkg::ST_SCAN: begin
        if ((n_r < lcount_r) && any_cand) begin
          ctrl.step = 1'b1;
          n_nxt     = n_r + LW'(1);
          if (n_r != '0) begin
            best_len_nxt = n_r + LW'(1);
            best_off_nxt = first_off;
          end
        end else begin
          state_nxt = lz77_pkg::ST_EMIT;
        end
      end
      lz77_pkg::ST_EMIT: begin
        if (!out_valid_r) begin
          emit_go   = 1'b1;
          rem_nxt   = best_len_r;
          state_nxt = lz77_pkg::ST_PUSH;
        end
      end
      lz77_pkg::ST_PUSH: begin
        ctrl.push  = 1'b1;
        rem_nxt    = rem_r - LW'(1);
        lcount_nxt = lcount_r - LW'(1);
        if (hcount_r != OW'(HISTORY_DEPTH)) begin
          hcount_nxt = hcount_r + OW'(1);
        end
        if (rem_r == LW'(1)) begin
          if (drain_r && (lcount_r != LW'(1))) begin
            state_nxt = lz77_pkg::ST_LOAD;
          end else if (drain_r) begin
            hcount_nxt = '0;
            drain_nxt  = 1'b0;
            state_nxt  = lz77_pkg::ST_IDLE;
          end else begin
            state_nxt = lz77_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = lz77_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lz77_pkg::ST_IDLE;
      lcount_r <= '0;
      hcount_r <= '0;
      drain_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      lcount_r <= lcount_nxt;
      hcount_r <= hcount_nxt;
      drain_r  <= drain_nxt;
    end
  end

  // search bookkeeping
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    best_len_r <= best_len_nxt;
    best_off_r <= best_off_nxt;
    rem_r      <= rem_nxt;
  end

  // lookahead buffer: write at the fill point, shift down on push
  always_ff @(posedge clk) begin
    if (in_take) begin
      la_r[lcount_r[LAW-1:0]] <= in_data_byte;
    end else if (ctrl.push) begin
      for (int i = 0; i < MAX_MATCH - 1; i++) begin
        la_r[i] <= la_r[i+1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_off_r   <= best_off_r;
      out_len_r   <= best_len_r;
      out_first_r <= la_r[0];
      out_last_r  <= !drain_r || (lcount_r == best_len_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_match_offset = out_off_r;
  assign out_match_length = out_len_r;
  assign out_lead_byte    = out_first_r;
  assign out_run_last     = out_last_r;

endmodule

// ----- src/lz77_checker.sv -----
// port-level checks of the lz77 token compressor, bound to the top level
module lz77_checker #(
  parameter int OW = 8,
  parameter int LW = 6
) (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input logic [OW-1:0] out_match_offset,
  input logic [LW-1:0] out_match_length,
  input logic [7:0]    out_lead_byte,
  input logic          out_run_last
);

  // a stalled token is held unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match_offset)
      && $stable(out_match_length) && $stable(out_lead_byte) && $stable(out_run_last))
    else $error("token changed while stalled");

  // every token consumes at least one byte
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_match_length != '0)
    else $error("zero length token");

  // a literal consumes exactly one byte
  a_literal_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_match_offset == '0) |-> out_match_length == LW'(1))
    else $error("literal with length above one");

  // a back reference is longer than one byte and never extends beyond its own distance
  a_ref_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_match_offset != '0) |->
      (out_match_length > LW'(1)) && (OW'(out_match_length) <= out_match_offset))
    else $error("back reference length out of range");

endmodule

bind lz77_token_compressor_top lz77_checker #(
  .OW ($clog2(HISTORY_DEPTH + 1)),
  .LW ($clog2(MAX_MATCH + 1))
) u_lz77_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_match_offset (out_match_offset),
  .out_match_length (out_match_length),
  .out_lead_byte    (out_lead_byte),
  .out_run_last     (out_run_last)
);

// ----- tb/tb_lz77_token_compressor_top.sv -----
// testbench of the lz77 token compressor: random and directed byte streams against a predictor
`timescale 1ns / 1ps

// scoreboard: predicts tokens from accepted bytes and checks the emitted ones
class lz77_token_scoreboard;
  typedef struct packed {
    logic [7:0] offset;
    logic [5:0] length;
    logic [7:0] first;
    logic       last;
  } token_t;

  logic [7:0] hist[128];
  int unsigned hist_head;
  int unsigned hist_count;
  logic [7:0] look[32];
  int unsigned look_count;
  token_t pending_tokens[$];
  int unsigned error_count;

  function new();
    hist_head = 0;
    hist_count = 0;
    look_count = 0;
    error_count = 0;
  endfunction

  function logic [7:0] hist_byte(int unsigned i);
    return hist[(hist_head + i) % 128];
  endfunction

  function void hist_push(logic [7:0] b);
    hist[(hist_head + hist_count) % 128] = b;
    if (hist_count < 128) hist_count++;
    else hist_head = (hist_head + 1) % 128;
  endfunction

  // longest earlier match for the lookahead, nearest offset wins ties
  function void make_token(bit last);
    int unsigned best_off;
    int unsigned best_len;
    int unsigned n;
    int unsigned p;
    token_t t;
    best_off = 0;
    best_len = 1;
    for (int unsigned d = 1; d <= hist_count; d++) begin
      p = hist_count - d;
      if (hist_byte(p) == look[0]) begin
        n = 0;
        while (n < d && n < look_count && look[n] == hist_byte(p + n)) n++;
        if (n > best_len) begin
          best_off = d;
          best_len = n;
        end
      end
    end
    t.offset = best_off[7:0];
    t.length = best_len[5:0];
    t.first = look[0];
    t.last = last;
    pending_tokens.push_back(t);
    for (int unsigned i = 0; i < best_len; i++) hist_push(look[i]);
    for (int unsigned i = 0; i + best_len < look_count; i++) look[i] = look[i + best_len];
    look_count -= best_len;
  endfunction

  function void note_request(logic [7:0] b, bit stream_end);
    if (look_count < 32) begin
      look[look_count] = b;
      look_count++;
    end
    if (!stream_end) begin
      if (look_count >= 32) make_token(1'b1);
    end else begin
      while (look_count > 0) make_token(look_count == 0);
      pending_tokens[$].last = 1'b1;
      hist_head = 0;
      hist_count = 0;
      look_count = 0;
    end
  endfunction

  function void check_token(logic [7:0] offset, logic [5:0] length,
                            logic [7:0] first, logic last);
    token_t e;
    if (pending_tokens.size() == 0) begin
      $error("token with none expected: off %0d len %0d", offset, length);
      error_count++;
      return;
    end
    e = pending_tokens.pop_front();
    if (offset !== e.offset) begin
      $error("match_offset expected %0d actual %0d", e.offset, offset);
      error_count++;
    end
    if (length !== e.length) begin
      $error("match_length expected %0d actual %0d", e.length, length);
      error_count++;
    end
    if (first !== e.first) begin
      $error("lead_byte expected %0h actual %0h", e.first, first);
      error_count++;
    end
    if (last !== e.last) begin
      $error("run_last expected %0d actual %0d", e.last, last);
      error_count++;
    end
  endfunction
endclass

module tb_lz77_token_compressor_top;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_data_byte = '0;
  logic in_stream_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_match_offset;
  logic [5:0] out_match_length;
  logic [7:0] out_lead_byte;
  logic out_run_last;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_off = 1'b0;
  lz77_token_scoreboard token_board;

  lz77_token_compressor_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_stream_end(in_stream_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_match_offset(out_match_offset), .out_match_length(out_match_length),
    .out_lead_byte(out_lead_byte), .out_run_last(out_run_last)
  );

  always #5 clk = ~clk;

  // byte sender: one request, random idle cycles first; valid drops only while idling
  task automatic send_byte(logic [7:0] b, bit e);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_stream_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    token_board.note_request(b, e);
  endtask

  // random stream: repeats from an alphabet so matches occur
  task automatic send_stream(int unsigned len, int unsigned alphabet);
    logic [7:0] s[$];
    logic [7:0] b;
    int unsigned k;
    for (int unsigned i = 0; i < len; i++) begin
      if (s.size() > 2 && $urandom_range(2) == 0) begin
        k = $urandom_range(s.size() - 1);
        b = s[k];
      end else if (alphabet == 256) b = 8'($urandom_range(255));
      else b = 8'($urandom_range(alphabet - 1));
      s.push_back(b);
      send_byte(b, i == len - 1);
    end
  endtask

  // token receiver
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      token_board.check_token(out_match_offset, out_match_length, out_lead_byte, out_run_last);
    out_ready <= !hold_off && !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off to fill the block
  task automatic long_hold_off();
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  endtask

  initial begin
    #20_000_000;
    $display("[lz77_token_compressor_top] ERROR");
    $finish;
  end

  initial begin
    int unsigned guard;
    token_board = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: single literal, zero/ones extremes, long run, three distinct bytes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    for (int i = 0; i < 20; i++) send_byte(8'hA5, i == 19);
    for (int i = 0; i < 3; i++) send_byte(8'h5A ^ i[7:0], i == 2);
    // random phases with idling variants
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 73) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 24 : 73) : 0;
      if (ph == 0) begin
        fork
          long_hold_off();
        join_none
        send_stream(50, 4);
      end
      send_stream($urandom_range(10, 40), 256);
      send_stream($urandom_range(20, 40), 3);
      send_stream($urandom_range(1, 6), 2);
    end
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    guard = 0;
    while (token_board.pending_tokens.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (token_board.error_count == 0 && token_board.pending_tokens.size() == 0)
      $display("[lz77_token_compressor_top] OK");
    else
      $display("[lz77_token_compressor_top] ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
src/lz77_pkg.sv
src/lz77_hist_cell.sv
src/lz77_token_compressor_top.sv
src/lz77_checker.sv
tb/tb_lz77_token_compressor_top.sv
